[hw/rtl/frsqrt_pkg.sv]
package frsqrt_pkg;

    localparam logic [31:0] MAGIC_RSQRT = 32'h5f375a86;
    localparam logic [31:0] MAGIC_SQRT  = 32'h5f3759df;
    localparam logic [31:0] ONE_HALF    = 32'h3f000000;
    localparam logic [31:0] THREE_HALF  = 32'h3fc00000;
    localparam logic [31:0] CANON_NAN   = 32'h7fc00000;

    localparam logic REQ_RSQRT = 1'b0;
    localparam logic REQ_SQRT  = 1'b1;

    // Round a magnitude given as sign, exponent e (value = m * 2^(e-172)),
    // and a normalised-or-not 50-bit significand with sticky in bit 0.
    // m holds the exact value scaled; we find leading one and round to binary32.
    function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                             input logic [49:0] m);
        // value = m * 2^(e - 172): m bit 49 weight 2^(e-123)
        logic [5:0]  lz;
        logic [49:0] n;
        logic signed [12:0] be;
        logic [49:0] sh;
        logic [5:0]  d;
        logic [23:0] mant;
        logic        g, st;
        logic [24:0] r;
        logic [31:0] res;
        lz = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) lz = 6'(49 - i);
        end
        n  = m << lz;
        // n bit 49 has weight 2^(e-123-lz); biased exponent = e-123-lz+127 = e+4-lz
        be = 13'(e) + 13'sd4 - 13'(lz);
        if (be < 13'sd1) begin
            // subnormal: shift right by 1-be
            if (be < -13'sd48) begin
                d = 6'd50;
            end else begin
                d = 6'(13'sd1 - be);
            end
            sh = n >> d;
            st = |(n & ~(50'h3ffffffffffff << d));
            n  = {sh[49:1], sh[0] | st};
            be = 13'sd0;
        end
        mant = n[49:26];
        g    = n[25];
        st   = |n[24:0];
        r    = {1'b0, mant} + 25'(g & (st | mant[0]));
        if (m == 50'd0) begin
            res = {s, 31'd0};
        end else if (be == 13'sd0) begin
            // subnormal: r may carry into the normal range
            res = {s, 8'(r[23]), r[22:0]};
        end else if (r[24]) begin
            if (be + 13'sd1 >= 13'sd255) res = {s, 8'hff, 23'd0};
            else res = {s, 8'(be + 13'sd1), r[23:1]};
        end else if (be >= 13'sd255) begin
            res = {s, 8'hff, 23'd0};
        end else begin
            res = {s, 8'(be), r[22:0]};
        end
        return res;
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [23:0] ma, mb;
        logic signed [11:0] ea, eb;
        logic [47:0] p;
        logic s;
        logic [31:0] res;
        s  = a[31] ^ b[31];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(a[30:23]));
        eb = (b[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(b[30:23]));
        p  = ma * mb;
        if (is_nan(a) || is_nan(b)) begin
            res = CANON_NAN;
        end else if (is_inf(a) || is_inf(b)) begin
            if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) res = CANON_NAN;
            else res = {s, 8'hff, 23'd0};
        end else begin
            // p bit 46 weight 2^(ea+eb-254); in fp_round m bit 49 weight 2^(e-123),
            // p placed at m[48:1]: p bit46 -> m bit47 weight 2^(e-125) => e = ea+eb-129
            res = fp_round(s, ea + eb - 12'sd129, {1'b0, p, 1'b0});
        end
        return res;
    endfunction

    // a + b
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y, res;
        logic [23:0] mx, my;
        logic signed [11:0] ex, ey;
        logic [11:0] d;
        logic [49:0] wx, wy, wys, sum;
        logic stk;
        if (a[30:0] >= b[30:0]) begin
            x = a; y = b;
        end else begin
            x = b; y = a;
        end
        mx = {x[30:23] != 8'd0, x[22:0]};
        my = {y[30:23] != 8'd0, y[22:0]};
        ex = (x[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(x[30:23]));
        ey = (y[30:23] == 8'd0) ? 12'sd1 : 12'($unsigned(y[30:23]));
        d  = 12'(ex - ey);
        wx = {2'b00, mx, 24'd0};
        wy = {2'b00, my, 24'd0};
        if (d > 12'd49) begin
            wys = {49'd0, |wy};
        end else begin
            wys = wy >> d;
            stk = |(wy & ~(50'h3ffffffffffff << d));
            wys[0] = wys[0] | stk;
        end
        if (x[31] == y[31]) sum = wx + wys;
        else sum = wx - wys;
        if (is_nan(a) || is_nan(b)) begin
            res = CANON_NAN;
        end else if (is_inf(a) && is_inf(b)) begin
            res = (a[31] == b[31]) ? a : CANON_NAN;
        end else if (is_inf(x)) begin
            res = x;
        end else if (sum == 50'd0) begin
            res = {a[31] & b[31], 31'd0};
        end else begin
            // mx bit 23 at m bit 47, weight 2^(ex-127) => e = ex+(-127+125) ... e-125 = ex-127
            res = fp_round(x[31], ex - 12'sd2, sum);
        end
        return res;
    endfunction

endpackage

[hw/rtl/fast_rsqrt_and_sqrt_estimate_top.sv]
// channel | dir | tdata                   | tuser
// s_      | in  | [31:0] value_bits       | [0] req_type
// m_      | out | [31:0] result_bits      | none
//
// Seven register stages: seed, 0.5*x, *y, *y, 1.5-, y*, x* (or pass).
// One transfer per cycle while the pipe is not stalled; m_tvalid rises once the
// accepted item has moved through each stage in turn and reached the last one.
// aresetn (synchronous, active low) clears the stage valid bits only.
// A stall at m_tready with a result waiting freezes all stages together and
// drops s_tready (s_tready = !m_tvalid || m_tready); bubbles stay where they are.
module fast_rsqrt_and_sqrt_estimate_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result_bits
);
    localparam int N = 7;

    typedef struct packed {
        logic        mode;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
    } stage_t;

    stage_t     st_reg [N];
    stage_t     st_next[N];
    logic [N-1:0] vld_reg;
    logic       adv;

    // advance when the last stage is empty or being taken; a hole moves up too
    assign adv      = !vld_reg[N-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[N-1];

    always_comb begin
        logic [31:0] ashr;
        ashr = {s_tdata[31], s_tdata[31:1]};
        st_next[0].mode = s_tuser;
        st_next[0].x    = s_tdata;
        st_next[0].y    = ((s_tuser == frsqrt_pkg::REQ_SQRT) ? frsqrt_pkg::MAGIC_SQRT
                                                            : frsqrt_pkg::MAGIC_RSQRT) - ashr;
        st_next[0].t    = 32'd0;
        for (int i = 1; i < N; i++) st_next[i] = st_reg[i-1];
        st_next[1].t = frsqrt_pkg::fp_mul(frsqrt_pkg::ONE_HALF, st_reg[0].x);
        st_next[2].t = frsqrt_pkg::fp_mul(st_reg[1].t, st_reg[1].y);
        st_next[3].t = frsqrt_pkg::fp_mul(st_reg[2].t, st_reg[2].y);
        st_next[4].t = frsqrt_pkg::fp_add(frsqrt_pkg::THREE_HALF, {~st_reg[3].t[31],
                                                                 st_reg[3].t[30:0]});
        st_next[5].t = frsqrt_pkg::fp_mul(st_reg[4].y, st_reg[4].t);
        st_next[6].t = (st_reg[5].mode == frsqrt_pkg::REQ_SQRT)
                     ? frsqrt_pkg::fp_mul(st_reg[5].x, st_reg[5].t) : st_reg[5].t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[N-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N; i++) st_reg[i] <= st_next[i];
        end
    end

    assign m_tdata = frsqrt_pkg::is_nan(st_reg[N-1].t) ? frsqrt_pkg::CANON_NAN
                                                       : st_reg[N-1].t;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item lost");
endmodule
